>>> sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types, constants and helpers of the complex arithmetic unit
// Holds the command codes, the work-queue entry and the saturating clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   // operand format
   localparam int DATA_W   = 16;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int MAG_W    = PROD_W;

   // work queue between front and back
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // quotient digits produced by the back end, one a cycle
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // command codes
   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_SUB     = 3'd1;
   localparam logic [2:0] CMD_MUL     = 3'd2;
   localparam logic [2:0] CMD_DIV     = 3'd3;
   localparam logic [2:0] CMD_LESS    = 3'd4;
   localparam logic [2:0] CMD_GREATER = 3'd5;

   // clamp limits as magnitudes
   localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (DATA_W - 1)) - 64'd1);
   localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (DATA_W - 1));
   // quotient at or above this means certain overflow
   localparam logic [MAG_W-1:0] QUO_CAP = MAG_W'(64'd1 << DATA_W);

   // one job for the back end: either a finished result or a division
   typedef struct packed {
      logic                     is_div;
      logic [DATA_W-1:0]        res_re;
      logic [DATA_W-1:0]        res_im;
      logic                     cmp;
      logic                     dbz;
      logic                     sat;
      logic                     re_neg;
      logic [MAG_W-1:0]         re_mag;
      logic                     im_neg;
      logic [MAG_W-1:0]         im_mag;
      logic [MAG_W-1:0]         den;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_beat_type;

   // clamp a sign/magnitude value to DATA_W bits: {clipped, value}
   function automatic logic [DATA_W:0] clamp_q(input logic neg, input logic [MAG_W-1:0] mag);
      logic [MAG_W-1:0] lim;
      logic [MAG_W-1:0] m;
      logic             s;
      logic [MAG_W-1:0] v;
      lim = neg ? NEG_LIM : POS_LIM;
      s   = mag > lim;
      m   = s ? lim : mag;
      v   = neg ? (MAG_W'(0) - m) : m;
      return {s, v[DATA_W-1:0]};
   endfunction

endpackage

`default_nettype wire

>>> sv/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: operand intake and classification
// Registers the operand products, then resolves add, subtract, multiply and
// compare in full, and hands divisions on as numerators and a divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [2:0]                   req_command,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_im,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_im,
   input  wire logic [cau_pkg::QCNT_W-1:0]   q_count,
   output cau_pkg::q_beat_type               push
);
   import cau_pkg::*;

   logic                     accept;
   logic                     is_cmp;
   logic                     s1_valid_ff;
   logic [2:0]               cmd_ff;
   logic signed [DATA_W-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;

   // hold off once the queue could not take every beat in flight
   assign busy   = (QCNT_W'(q_count) + QCNT_W'(s1_valid_ff)) >= QCNT_W'(QDEPTH);
   assign accept = start && !busy;
   assign is_cmp = (req_command == CMD_LESS) || (req_command == CMD_GREATER);

   // form the products; compares square the first operand instead
   always_comb begin
      p0_in = req_a_re * (is_cmp ? req_a_re : req_b_re);
      p1_in = req_a_im * (is_cmp ? req_a_im : req_b_im);
      p2_in = req_a_re * req_b_im;
      p3_in = req_a_im * req_b_re;
      p4_in = req_b_re * req_b_re;
      p5_in = req_b_im * req_b_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         ar_ff  <= req_a_re;
         ai_ff  <= req_a_im;
         br_ff  <= req_b_re;
         bi_ff  <= req_b_im;
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
      end
   end

   // classify and resolve the registered beat
   logic signed [SUM_W-1:0] x_re, x_im;
   logic [SUM_W-1:0]        abs_re, abs_im;
   logic [MAG_W-1:0]        m_re, m_im;
   logic [MAG_W-1:0]        den, mag_a;
   logic [DATA_W:0]         c_re, c_im;
   q_entry_type             e;

   always_comb begin
      den   = MAG_W'($unsigned(p4_ff)) + MAG_W'($unsigned(p5_ff));
      mag_a = MAG_W'($unsigned(p0_ff)) + MAG_W'($unsigned(p1_ff));
      x_re  = '0;
      x_im  = '0;
      case (cmd_ff)
         CMD_ADD: begin
            x_re = SUM_W'(ar_ff) + SUM_W'(br_ff);
            x_im = SUM_W'(ai_ff) + SUM_W'(bi_ff);
         end
         CMD_SUB: begin
            x_re = SUM_W'(ar_ff) - SUM_W'(br_ff);
            x_im = SUM_W'(ai_ff) - SUM_W'(bi_ff);
         end
         CMD_MUL: begin
            x_re = SUM_W'(p0_ff) - SUM_W'(p1_ff);
            x_im = SUM_W'(p2_ff) + SUM_W'(p3_ff);
         end
         CMD_DIV: begin
            x_re = SUM_W'(p0_ff) + SUM_W'(p1_ff);
            x_im = SUM_W'(p3_ff) - SUM_W'(p2_ff);
         end
         default: begin
            x_re = '0;
            x_im = '0;
         end
      endcase

      abs_re = x_re[SUM_W-1] ? (SUM_W'(0) - $unsigned(x_re)) : $unsigned(x_re);
      abs_im = x_im[SUM_W-1] ? (SUM_W'(0) - $unsigned(x_im)) : $unsigned(x_im);
      m_re   = abs_re[MAG_W-1:0];
      m_im   = abs_im[MAG_W-1:0];
      // multiply drops the fraction, truncating toward zero
      if (cmd_ff == CMD_MUL) begin
         m_re = m_re >> FRAC_W;
         m_im = m_im >> FRAC_W;
      end
      c_re = clamp_q(x_re[SUM_W-1], m_re);
      c_im = clamp_q(x_im[SUM_W-1], m_im);

      e        = '0;
      e.re_neg = x_re[SUM_W-1];
      e.re_mag = abs_re[MAG_W-1:0];
      e.im_neg = x_im[SUM_W-1];
      e.im_mag = abs_im[MAG_W-1:0];
      e.den    = den;
      case (cmd_ff)
         CMD_ADD, CMD_SUB, CMD_MUL: begin
            e.res_re = c_re[DATA_W-1:0];
            e.res_im = c_im[DATA_W-1:0];
            e.sat    = c_re[DATA_W] | c_im[DATA_W];
         end
         CMD_DIV: begin
            e.dbz    = (den == '0);
            e.is_div = (den != '0);
         end
         CMD_LESS:    e.cmp = mag_a < den;
         CMD_GREATER: e.cmp = mag_a > den;
         default:     e.cmp = 1'b0;
      endcase
   end

   assign push.valid = s1_valid_ff;
   assign push.entry = e;

endmodule

`default_nettype wire

>>> sv/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue: short work queue between front and back
// Small register FIFO; the front never pushes into a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cau_pkg::q_beat_type        push,
   input  wire logic                       pop,
   output cau_pkg::q_beat_type             head,
   output logic [cau_pkg::QCNT_W-1:0]      count
);
   import cau_pkg::*;

   q_entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)     rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push.valid) - QCNT_W'(do_pop);
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back: job execution and result register
// Passes finished results straight out; runs divisions on a restoring
// divider, one quotient bit a cycle for both parts at once.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cau_pkg::q_beat_type          head,
   output logic                              pop,
   output logic                              rsp_valid,
   output logic [cau_pkg::DATA_W-1:0]        rsp_res_re,
   output logic [cau_pkg::DATA_W-1:0]        rsp_res_im,
   output logic                              rsp_compare_true,
   output logic                              rsp_div_by_zero,
   output logic                              rsp_saturated
);
   import cau_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;

   // divider working set
   logic [MAG_W-1:0]        den_ff;
   logic [MAG_W-1:0]        rre_ff, rim_ff;
   logic [DATA_W-1:0]       xre_ff, xim_ff;
   logic [DATA_W-1:0]       qre_ff, qim_ff;
   logic                    nre_ff, nim_ff, ovre_ff, ovim_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]       out_re_ff, out_im_ff;
   logic                    out_cmp_ff, out_dbz_ff, out_sat_ff;

   logic [MAG_W:0]          tre, tim;
   logic                    bre, bim;
   logic [MAG_W-1:0]        rre_nx, rim_nx;
   logic [DATA_W-1:0]       qre_nx, qim_nx;
   logic [DATA_W:0]         c_re, c_im;
   logic                    load_div, pass, last;

   // one restoring step for each part
   always_comb begin
      tre    = {rre_ff, xre_ff[DATA_W-1]};
      tim    = {rim_ff, xim_ff[DATA_W-1]};
      bre    = tre >= {1'b0, den_ff};
      bim    = tim >= {1'b0, den_ff};
      rre_nx = bre ? MAG_W'(tre - {1'b0, den_ff}) : tre[MAG_W-1:0];
      rim_nx = bim ? MAG_W'(tim - {1'b0, den_ff}) : tim[MAG_W-1:0];
      qre_nx = {qre_ff[DATA_W-2:0], bre};
      qim_nx = {qim_ff[DATA_W-2:0], bim};
      c_re   = clamp_q(nre_ff, ovre_ff ? QUO_CAP : MAG_W'(qre_nx));
      c_im   = clamp_q(nim_ff, ovim_ff ? QUO_CAP : MAG_W'(qim_nx));
   end

   // sequence the jobs
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      load_div     = 1'b0;
      pass         = 1'b0;
      last         = 1'b0;
      out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.is_div) begin
                  load_div = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  pass         = 1'b1;
                  out_valid_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               last         = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // load or advance the divider
   always_ff @(posedge clock) begin
      if (load_div) begin
         den_ff  <= head.entry.den;
         nre_ff  <= head.entry.re_neg;
         nim_ff  <= head.entry.im_neg;
         rre_ff  <= head.entry.re_mag >> DATA_W - FRAC_W;
         rim_ff  <= head.entry.im_mag >> DATA_W - FRAC_W;
         xre_ff  <= DATA_W'(head.entry.re_mag) << FRAC_W;
         xim_ff  <= DATA_W'(head.entry.im_mag) << FRAC_W;
         ovre_ff <= {FRAC_W'(0), head.entry.re_mag} >= {head.entry.den, FRAC_W'(0)};
         ovim_ff <= {FRAC_W'(0), head.entry.im_mag} >= {head.entry.den, FRAC_W'(0)};
         qre_ff  <= '0;
         qim_ff  <= '0;
      end else if (state_ff == ST_DIV) begin
         rre_ff <= rre_nx;
         rim_ff <= rim_nx;
         xre_ff <= xre_ff << 1;
         xim_ff <= xim_ff << 1;
         qre_ff <= qre_nx;
         qim_ff <= qim_nx;
      end
   end

   // hold the result for its beat
   always_ff @(posedge clock) begin
      if (pass) begin
         out_re_ff  <= head.entry.res_re;
         out_im_ff  <= head.entry.res_im;
         out_cmp_ff <= head.entry.cmp;
         out_dbz_ff <= head.entry.dbz;
         out_sat_ff <= head.entry.sat;
      end else if (last) begin
         out_re_ff  <= c_re[DATA_W-1:0];
         out_im_ff  <= c_im[DATA_W-1:0];
         out_cmp_ff <= 1'b0;
         out_dbz_ff <= 1'b0;
         out_sat_ff <= c_re[DATA_W] | c_im[DATA_W];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_res_re       = out_re_ff;
   assign rsp_res_im       = out_im_ff;
   assign rsp_compare_true = out_cmp_ff;
   assign rsp_div_by_zero  = out_dbz_ff;
   assign rsp_saturated    = out_sat_ff;

endmodule

`default_nettype wire

>>> sv/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit: complex-number ALU on signed Q8.8 operands
// Add, subtract, multiply, divide and squared-magnitude compares.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive req_command and the four operand parts and raise start; the beat
//    is taken at a rising edge where start is high and busy is low.
//  - Each beat gives one result on the rsp_ ports, shown for one cycle with
//    rsp_valid high, in the order the beats were taken.
//  - Add, subtract, multiply, compare and zero-divisor beats pass through the
//    product register, the queue and the result register; one such beat can
//    be taken every cycle while busy is low.
//  - Divide: the back end pops the beat and loads the divider, then forms the
//    quotient bit by bit before it takes the next beat; its rsp_valid
//    follows the last bit. Later beats wait behind it in a four-entry queue.
//  - busy rises when the queue and the product stage together hold four
//    beats.
//  - The receiver cannot stall; every result is delivered in its cycle.
//  - Reset empties the queue and the pipeline; no beat is delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [2:0]                        req_command,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_im,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_im,
   output logic                                   rsp_valid,
   output logic signed [cau_pkg::DATA_W-1:0]      rsp_res_re,
   output logic signed [cau_pkg::DATA_W-1:0]      rsp_res_im,
   output logic                                   rsp_compare_true,
   output logic                                   rsp_div_by_zero,
   output logic                                   rsp_saturated
);
   import cau_pkg::*;

   q_beat_type          push;
   q_beat_type          head;
   logic                pop;
   logic [QCNT_W-1:0]   q_count;
   logic [DATA_W-1:0]   res_re, res_im;

   cau_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_a_re    (req_a_re),
      .req_a_im    (req_a_im),
      .req_b_re    (req_b_re),
      .req_b_im    (req_b_im),
      .q_count     (q_count),
      .push        (push)
   );

   cau_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   cau_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_res_re       (res_re),
      .rsp_res_im       (res_im),
      .rsp_compare_true (rsp_compare_true),
      .rsp_div_by_zero  (rsp_div_by_zero),
      .rsp_saturated    (rsp_saturated)
   );

   assign rsp_res_re = $signed(res_re);
   assign rsp_res_im = $signed(res_im);

endmodule

`default_nettype wire

>>> test/tb_complex_arith_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arith_unit: self-checking bench for the complex arithmetic unit
// Drives directed and random command beats with random gaps, predicts each
// result in fixed point and checks the result beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

// expected results in issue order, with the fixed-point prediction
class cau_scoreboard;
   typedef struct {
      logic [15:0] re;
      logic [15:0] im;
      logic        cmp;
      logic        dbz;
      logic        sat;
   } cau_result_type;

   cau_result_type pending[$];
   int             errors;

   // clamp a signed wide value to 16 bits
   static function logic [15:0] clip(input longint v, inout logic sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 16'h7fff;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // divide toward zero
   static function longint div_tz(input longint n, input longint d);
      longint q;
      q = (n < 0 ? -n : n) / d;
      return n < 0 ? -q : q;
   endfunction

   function void note_request(input logic [2:0] cmd, input logic signed [15:0] ar,
                              input logic signed [15:0] ai, input logic signed [15:0] br,
                              input logic signed [15:0] bi);
      cau_result_type r;
      longint         x, y, d, ma, mb;
      r = '{default: '0};
      ma = longint'(ar) * ar + longint'(ai) * ai;
      mb = longint'(br) * br + longint'(bi) * bi;
      case (cmd)
         cau_pkg::CMD_ADD: begin
            r.re = clip(longint'(ar) + br, r.sat);
            r.im = clip(longint'(ai) + bi, r.sat);
         end
         cau_pkg::CMD_SUB: begin
            r.re = clip(longint'(ar) - br, r.sat);
            r.im = clip(longint'(ai) - bi, r.sat);
         end
         cau_pkg::CMD_MUL: begin
            x = longint'(ar) * br - longint'(ai) * bi;
            y = longint'(ar) * bi + longint'(ai) * br;
            r.re = clip(div_tz(x, 256), r.sat);
            r.im = clip(div_tz(y, 256), r.sat);
         end
         cau_pkg::CMD_DIV: begin
            d = mb;
            if (d == 0) r.dbz = 1'b1;
            else begin
               x = longint'(ar) * br + longint'(ai) * bi;
               y = longint'(ai) * br - longint'(ar) * bi;
               r.re = clip(div_tz(x * 256, d), r.sat);
               r.im = clip(div_tz(y * 256, d), r.sat);
            end
         end
         cau_pkg::CMD_LESS:    r.cmp = ma < mb;
         cau_pkg::CMD_GREATER: r.cmp = ma > mb;
         default: ;
      endcase
      pending.push_back(r);
   endfunction

   function void check_result(input logic [15:0] re, input logic [15:0] im,
                              input logic cmp, input logic dbz, input logic sat);
      cau_result_type e;
      if (pending.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
         $error("res_re expected %h actual %h", e.re, re); errors++;
      end
      if (im !== e.im) begin
         $error("res_im expected %h actual %h", e.im, im); errors++;
      end
      if (cmp !== e.cmp) begin
         $error("compare_true expected %b actual %b", e.cmp, cmp); errors++;
      end
      if (dbz !== e.dbz) begin
         $error("div_by_zero expected %b actual %b", e.dbz, dbz); errors++;
      end
      if (sat !== e.sat) begin
         $error("saturated expected %b actual %b", e.sat, sat); errors++;
      end
   endfunction
endclass

module tb_complex_arith_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 550;
   localparam int STALL_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_command = '0;
   logic signed [15:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_res_re, rsp_res_im;
   logic               rsp_compare_true, rsp_div_by_zero, rsp_saturated;

   cau_scoreboard results = new();
   int            quiet_cycles = 0;
   bit            done = 1'b0;

   complex_arith_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_a_re(req_a_re), .req_a_im(req_a_im),
      .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_compare_true(rsp_compare_true), .rsp_div_by_zero(rsp_div_by_zero),
      .rsp_saturated(rsp_saturated)
   );

   always #5 clock = ~clock;

   // note taken beats, check result beats, count idle cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            results.note_request(req_command, req_a_re, req_a_im, req_b_re, req_b_im);
            quiet_cycles <= 0;
         end else if (rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid)
            results.check_result(rsp_res_re, rsp_res_im, rsp_compare_true,
                                 rsp_div_by_zero, rsp_saturated);
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!done && quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_part();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'(signed'($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // gap before a beat: mostly none or short, now and then long
   task automatic idle_gap();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: n = 0;
         9: n = $urandom_range(10, 40);
         default: n = $urandom_range(1, 3);
      endcase
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // present one beat at the falling edge and hold it until taken
   task automatic send_beat(input logic [2:0] cmd, input logic signed [15:0] ar,
                            input logic signed [15:0] ai, input logic signed [15:0] br,
                            input logic signed [15:0] bi, input bit gaps);
      if (gaps) begin
         if ($urandom_range(0, 3) != 0) begin
            idle_gap();
         end
      end
      req_command <= cmd;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [2:0] c;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every command on extremes, zero divisor and unused codes
      for (int k = 0; k < 6; k++) begin
         c = 3'(k);
         send_beat(c, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 0);
         send_beat(c, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
         send_beat(c, 16'sh0100, 16'sh0200, 16'sh0080, -16'sh0100, 0);
      end
      send_beat(cau_pkg::CMD_DIV, 16'sh1234, -16'sh0567, 16'sd0, 16'sd0, 0);
      send_beat(cau_pkg::CMD_DIV, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd1, 0);
      send_beat(cau_pkg::CMD_LESS, 16'sd3, 16'sd4, -16'sd4, 16'sd3, 0);
      send_beat(cau_pkg::CMD_GREATER, 16'sd3, 16'sd4, -16'sd4, 16'sd3, 0);
      send_beat(3'd6, 16'sh7fff, 16'sd1, 16'sd1, 16'sd1, 0);
      send_beat(3'd7, 16'sh8000, 16'sd1, 16'sd1, 16'sd1, 0);

      // random: mostly valid commands, a few unused codes and back-to-back runs
      for (int n = 0; n < N_RANDOM; n++) begin
         c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
         send_beat(c, pick_part(), pick_part(), pick_part(), pick_part(),
                   (n / 60) % 3 != 1);
      end
      start <= 1'b0;

      // drain: wait until nothing is expected, then for the pipeline to settle
      while (results.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      done = 1'b1;
      if (results.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
